[sv/ssl_pkg.sv]
// Shared constants, types and state codes for the shortest superstring length block
`timescale 1ns / 1ps
package ssl_pkg;

  localparam int MAX_WORDS  = 12;
  localparam int MAX_CHARS  = 64;

  localparam int WIDX_W     = $clog2(MAX_WORDS + 1);
  localparam int WSEL_W     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int LEN_W      = $clog2(MAX_CHARS + 1);
  localparam int CHAR_W     = 8;
  localparam int CHAR_DEPTH = MAX_WORDS * MAX_CHARS;
  localparam int CHAR_AW    = $clog2(CHAR_DEPTH);
  localparam int EXT_DEPTH  = MAX_WORDS * MAX_WORDS;
  localparam int EXT_AW     = $clog2(EXT_DEPTH);
  localparam int BEST_DEPTH = (1 << MAX_WORDS) * MAX_WORDS;
  localparam int BEST_AW    = $clog2(BEST_DEPTH);
  localparam int SLEN_W     = 10;
  localparam int STAT_W     = 2;
  localparam int COST_W     = SLEN_W + 1;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MANY = 2'd1;
  localparam logic [STAT_W-1:0] ST_LONG = 2'd2;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_SOLVE = 1'b1;

  localparam logic [COST_W-1:0] BIG_COST = '1;

  typedef logic [MAX_WORDS-1:0] wmask_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PR_CHK,
    S_PR_LA,
    S_PR_LB,
    S_PR_ADV,
    S_CMP_RD,
    S_CMP_CK,
    S_DP_MASK,
    S_DP_LAST,
    S_DP_P,
    S_DP_ADD,
    S_FIN_RD,
    S_FIN_CK,
    S_DONE
  } state_t;

endpackage

[sv/ssl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data
`timescale 1ns / 1ps
module ssl_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                         wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/shortest_superstring_length.sv]
// Top level: word store, containment and overlap passes, subset table solver
`timescale 1ns / 1ps
// Each load request (in_tuser 0) writes one character into the word store while the word
// and length limits hold. A solve request (in_tuser 1) runs until its single result is
// ready: it steps over every ordered pair of words in the containment and overlap passes,
// comparing the pairs it does not skip character by character, then walks each (subset,
// last word, predecessor) step of the subset table, bound by the one read port of the table
// memory. No new request is taken during a solve. The result sits in an output register,
// so loads continue while it waits to be taken.
module shortest_superstring_length (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ssl_pkg::IN_TDATA_W-1:0]    in_tdata,   // [7:0] char_code
  input  logic                              in_tuser,   // [0] func
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ssl_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [9:0] super_len
  output logic [ssl_pkg::STAT_W-1:0]        out_tuser   // [1:0] status
);

  ssl_pkg::state_t state_r, state_nxt;

  logic [ssl_pkg::WIDX_W-1:0]  wc_r, wc_nxt;
  logic [ssl_pkg::LEN_W-1:0]   cur_r, cur_nxt;
  logic [1:0]                  err_r, err_nxt;
  ssl_pkg::wmask_t             keep_r, keep_nxt;
  logic [ssl_pkg::WIDX_W-1:0]  ia_r, ia_nxt, jb_r, jb_nxt;
  logic                        ov_r, ov_nxt;
  logic [ssl_pkg::LEN_W-1:0]   la_r, la_nxt, lb_r, lb_nxt;
  logic [ssl_pkg::LEN_W-1:0]   off_r, off_nxt, len_r, len_nxt, pos_r, pos_nxt;
  ssl_pkg::wmask_t             mask_r, mask_nxt;
  logic [ssl_pkg::WIDX_W-1:0]  last_r, last_nxt, p_r, p_nxt;
  logic [ssl_pkg::COST_W-1:0]  v_r, v_nxt;
  logic [ssl_pkg::SLEN_W-1:0]  res_len_r, res_len_nxt;
  logic [ssl_pkg::STAT_W-1:0]  res_st_r, res_st_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [ssl_pkg::SLEN_W-1:0]  out_len_r, out_len_nxt;
  logic [ssl_pkg::STAT_W-1:0]  out_st_r, out_st_nxt;

  logic [ssl_pkg::LEN_W-1:0]   wl_r [ssl_pkg::MAX_WORDS];
  logic                        wl_we;
  logic [ssl_pkg::LEN_W-1:0]   wl_wdata;
  logic [ssl_pkg::WIDX_W-1:0]  wl_sel;
  logic [ssl_pkg::LEN_W-1:0]   wl_q;

  logic                        char_we;
  logic [ssl_pkg::CHAR_AW-1:0] char_waddr, char_ra, char_rb;
  logic [ssl_pkg::CHAR_W-1:0]  rd_a, rd_b;
  logic                        ext_we;
  logic [ssl_pkg::EXT_AW-1:0]  ext_waddr, ext_raddr;
  logic [ssl_pkg::LEN_W-1:0]   ext_wdata, ext_rdata;
  logic                        best_we;
  logic [ssl_pkg::BEST_AW-1:0] best_waddr, best_raddr, best_cur;
  logic [ssl_pkg::SLEN_W-1:0]  best_wdata, best_rdata;

  logic                        in_acc;
  logic                        pair_skip, pair_last, jb_last;
  logic                        cmp_eq, cmp_done, cmp_retry;
  logic                        last_end, p_end;
  ssl_pkg::wmask_t             bit_last, sub;
  logic [ssl_pkg::LEN_W:0]     retry_sum;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == ssl_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(ssl_pkg::OUT_TDATA_W - ssl_pkg::SLEN_W){1'b0}}, out_len_r};
  assign out_tuser  = out_st_r;

  assign wl_q = wl_r[wl_sel[ssl_pkg::WSEL_W-1:0]];

  assign pair_skip = (ia_r == jb_r) || !keep_r[ia_r[ssl_pkg::WSEL_W-1:0]]
                     || !keep_r[jb_r[ssl_pkg::WSEL_W-1:0]];
  assign jb_last   = (jb_r + ssl_pkg::WIDX_W'(1)) == wc_r;
  assign pair_last = jb_last && ((ia_r + ssl_pkg::WIDX_W'(1)) == wc_r);

  assign cmp_eq    = (rd_a == rd_b);
  assign cmp_done  = (pos_r + ssl_pkg::LEN_W'(1)) == len_r;
  assign retry_sum = {1'b0, off_r} + (ssl_pkg::LEN_W + 1)'(1) + {1'b0, len_r};
  assign cmp_retry = ov_r ? (len_r > ssl_pkg::LEN_W'(1)) : (retry_sum <= {1'b0, la_r});

  assign last_end = (last_r == wc_r);
  assign p_end    = (p_r == wc_r);
  assign bit_last = ssl_pkg::wmask_t'(1) << last_r;
  assign sub      = mask_r ^ bit_last;

  assign char_ra = ssl_pkg::CHAR_AW'(ia_r) * ssl_pkg::CHAR_AW'(ssl_pkg::MAX_CHARS)
                   + ssl_pkg::CHAR_AW'(ssl_pkg::LEN_W'(off_r + pos_r));
  assign char_rb = ssl_pkg::CHAR_AW'(jb_r) * ssl_pkg::CHAR_AW'(ssl_pkg::MAX_CHARS)
                   + ssl_pkg::CHAR_AW'(pos_r);
  assign char_waddr = ssl_pkg::CHAR_AW'(wc_r) * ssl_pkg::CHAR_AW'(ssl_pkg::MAX_CHARS)
                      + ssl_pkg::CHAR_AW'(cur_r);
  assign ext_waddr = ssl_pkg::EXT_AW'(ia_r) * ssl_pkg::EXT_AW'(ssl_pkg::MAX_WORDS)
                     + ssl_pkg::EXT_AW'(jb_r);
  assign ext_raddr = ssl_pkg::EXT_AW'(p_r) * ssl_pkg::EXT_AW'(ssl_pkg::MAX_WORDS)
                     + ssl_pkg::EXT_AW'(last_r);
  assign best_cur  = ssl_pkg::BEST_AW'(mask_r) * ssl_pkg::BEST_AW'(ssl_pkg::MAX_WORDS)
                     + ssl_pkg::BEST_AW'(last_r);
  assign best_waddr = best_cur;
  assign best_raddr = (state_r == ssl_pkg::S_FIN_RD)
                      ? ssl_pkg::BEST_AW'(keep_r) * ssl_pkg::BEST_AW'(ssl_pkg::MAX_WORDS)
                        + ssl_pkg::BEST_AW'(last_r)
                      : ssl_pkg::BEST_AW'(sub) * ssl_pkg::BEST_AW'(ssl_pkg::MAX_WORDS)
                        + ssl_pkg::BEST_AW'(p_r);

  ssl_ram #(.W(ssl_pkg::CHAR_W), .D(ssl_pkg::CHAR_DEPTH)) u_chars_a (
    .clk(clk), .we(char_we), .waddr(char_waddr), .wdata(in_tdata[ssl_pkg::CHAR_W-1:0]),
    .raddr(char_ra), .rdata(rd_a)
  );

  ssl_ram #(.W(ssl_pkg::CHAR_W), .D(ssl_pkg::CHAR_DEPTH)) u_chars_b (
    .clk(clk), .we(char_we), .waddr(char_waddr), .wdata(in_tdata[ssl_pkg::CHAR_W-1:0]),
    .raddr(char_rb), .rdata(rd_b)
  );

  ssl_ram #(.W(ssl_pkg::LEN_W), .D(ssl_pkg::EXT_DEPTH)) u_ext (
    .clk(clk), .we(ext_we), .waddr(ext_waddr), .wdata(ext_wdata),
    .raddr(ext_raddr), .rdata(ext_rdata)
  );

  ssl_ram #(.W(ssl_pkg::SLEN_W), .D(ssl_pkg::BEST_DEPTH)) u_best (
    .clk(clk), .we(best_we), .waddr(best_waddr), .wdata(best_wdata),
    .raddr(best_raddr), .rdata(best_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ssl_pkg::S_IDLE: begin
        if (in_acc && (in_tuser == ssl_pkg::FUNC_SOLVE)) begin
          if ((err_r != 2'b00) || (wc_r == '0)) begin
            state_nxt = ssl_pkg::S_DONE;
          end else begin
            state_nxt = ssl_pkg::S_PR_CHK;
          end
        end
      end
      ssl_pkg::S_PR_CHK: begin
        state_nxt = pair_skip ? ssl_pkg::S_PR_ADV : ssl_pkg::S_PR_LA;
      end
      ssl_pkg::S_PR_LA: begin
        state_nxt = ssl_pkg::S_PR_LB;
      end
      ssl_pkg::S_PR_LB: begin
        if (!ov_r && (wl_q > la_r)) begin
          state_nxt = ssl_pkg::S_PR_ADV;
        end else begin
          state_nxt = ssl_pkg::S_CMP_RD;
        end
      end
      ssl_pkg::S_PR_ADV: begin
        state_nxt = (pair_last && ov_r) ? ssl_pkg::S_DP_MASK : ssl_pkg::S_PR_CHK;
      end
      ssl_pkg::S_CMP_RD: begin
        state_nxt = ssl_pkg::S_CMP_CK;
      end
      ssl_pkg::S_CMP_CK: begin
        if (cmp_eq) begin
          state_nxt = cmp_done ? ssl_pkg::S_PR_ADV : ssl_pkg::S_CMP_RD;
        end else begin
          state_nxt = cmp_retry ? ssl_pkg::S_CMP_RD : ssl_pkg::S_PR_ADV;
        end
      end
      ssl_pkg::S_DP_MASK: begin
        if ((mask_r & ~keep_r) == '0) begin
          state_nxt = ssl_pkg::S_DP_LAST;
        end
      end
      ssl_pkg::S_DP_LAST: begin
        if (last_end) begin
          state_nxt = (mask_r == keep_r) ? ssl_pkg::S_FIN_RD : ssl_pkg::S_DP_MASK;
        end else if (mask_r[last_r[ssl_pkg::WSEL_W-1:0]] && (mask_r != bit_last)) begin
          state_nxt = ssl_pkg::S_DP_P;
        end
      end
      ssl_pkg::S_DP_P: begin
        if (p_end) begin
          state_nxt = ssl_pkg::S_DP_LAST;
        end else if (sub[p_r[ssl_pkg::WSEL_W-1:0]]) begin
          state_nxt = ssl_pkg::S_DP_ADD;
        end
      end
      ssl_pkg::S_DP_ADD: begin
        state_nxt = ssl_pkg::S_DP_P;
      end
      ssl_pkg::S_FIN_RD: begin
        if (last_end) begin
          state_nxt = ssl_pkg::S_DONE;
        end else if (keep_r[last_r[ssl_pkg::WSEL_W-1:0]]) begin
          state_nxt = ssl_pkg::S_FIN_CK;
        end
      end
      ssl_pkg::S_FIN_CK: begin
        state_nxt = ssl_pkg::S_FIN_RD;
      end
      ssl_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ssl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ssl_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    logic [ssl_pkg::LEN_W-1:0]  cur_v;
    logic [ssl_pkg::LEN_W-1:0]  k_v;
    logic [ssl_pkg::COST_W-1:0] t_v;
    cur_v = cur_r;
    k_v   = '0;
    t_v   = '0;
    wc_nxt = wc_r;
    cur_nxt = cur_r;
    err_nxt = err_r;
    keep_nxt = keep_r;
    ia_nxt = ia_r;
    jb_nxt = jb_r;
    ov_nxt = ov_r;
    la_nxt = la_r;
    lb_nxt = lb_r;
    off_nxt = off_r;
    len_nxt = len_r;
    pos_nxt = pos_r;
    mask_nxt = mask_r;
    last_nxt = last_r;
    p_nxt = p_r;
    v_nxt = v_r;
    res_len_nxt = res_len_r;
    res_st_nxt = res_st_r;
    out_valid_nxt = out_valid_r;
    out_len_nxt = out_len_r;
    out_st_nxt = out_st_r;
    wl_we = 1'b0;
    wl_wdata = cur_r;
    wl_sel = ia_r;
    char_we = 1'b0;
    ext_we = 1'b0;
    ext_wdata = lb_r;
    best_we = 1'b0;
    best_wdata = v_r[ssl_pkg::SLEN_W-1:0];

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ssl_pkg::S_IDLE: begin
        if (in_acc && (in_tuser == ssl_pkg::FUNC_LOAD)) begin
          if (wc_r >= ssl_pkg::WIDX_W'(ssl_pkg::MAX_WORDS)) begin
            err_nxt[0] = 1'b1;
          end else if (cur_r >= ssl_pkg::LEN_W'(ssl_pkg::MAX_CHARS)) begin
            err_nxt[1] = 1'b1;
          end else begin
            char_we = 1'b1;
            cur_v = cur_r + ssl_pkg::LEN_W'(1);
          end
          cur_nxt = cur_v;
          if (in_tlast) begin
            if ((wc_r < ssl_pkg::WIDX_W'(ssl_pkg::MAX_WORDS)) && (cur_v != '0)) begin
              wl_we = 1'b1;
              wl_wdata = cur_v;
              wc_nxt = wc_r + ssl_pkg::WIDX_W'(1);
            end
            cur_nxt = '0;
          end
        end else if (in_acc) begin
          res_len_nxt = '0;
          if (err_r[0]) begin
            res_st_nxt = ssl_pkg::ST_MANY;
          end else if (err_r[1]) begin
            res_st_nxt = ssl_pkg::ST_LONG;
          end else begin
            res_st_nxt = ssl_pkg::ST_OK;
          end
          keep_nxt = (ssl_pkg::wmask_t'(1) << wc_r) - ssl_pkg::wmask_t'(1);
          ia_nxt = '0;
          jb_nxt = '0;
          ov_nxt = 1'b0;
        end
      end
      ssl_pkg::S_PR_LA: begin
        wl_sel = ia_r;
        la_nxt = wl_q;
      end
      ssl_pkg::S_PR_LB: begin
        wl_sel = jb_r;
        lb_nxt = wl_q;
        pos_nxt = '0;
        if (ov_r) begin
          k_v = (la_r < wl_q) ? la_r : wl_q;
          len_nxt = k_v;
          off_nxt = la_r - k_v;
        end else begin
          len_nxt = wl_q;
          off_nxt = '0;
        end
      end
      ssl_pkg::S_PR_ADV: begin
        if (jb_last) begin
          jb_nxt = '0;
          if (pair_last) begin
            ia_nxt = '0;
            if (ov_r) begin
              mask_nxt = ssl_pkg::wmask_t'(1);
            end else begin
              ov_nxt = 1'b1;
            end
          end else begin
            ia_nxt = ia_r + ssl_pkg::WIDX_W'(1);
          end
        end else begin
          jb_nxt = jb_r + ssl_pkg::WIDX_W'(1);
        end
      end
      ssl_pkg::S_CMP_CK: begin
        if (cmp_eq && !cmp_done) begin
          pos_nxt = pos_r + ssl_pkg::LEN_W'(1);
        end else if (cmp_eq) begin
          if (ov_r) begin
            ext_we = 1'b1;
            ext_wdata = lb_r - len_r;
          end else begin
            keep_nxt[jb_r[ssl_pkg::WSEL_W-1:0]] = 1'b0;
          end
        end else begin
          pos_nxt = '0;
          off_nxt = off_r + ssl_pkg::LEN_W'(1);
          if (ov_r) begin
            len_nxt = len_r - ssl_pkg::LEN_W'(1);
            if (!cmp_retry) begin
              ext_we = 1'b1;
              ext_wdata = lb_r;
            end
          end
        end
      end
      ssl_pkg::S_DP_MASK: begin
        if ((mask_r & ~keep_r) != '0) begin
          mask_nxt = mask_r + ssl_pkg::wmask_t'(1);
        end else begin
          last_nxt = '0;
        end
      end
      ssl_pkg::S_DP_LAST: begin
        wl_sel = last_r;
        if (last_end) begin
          if (mask_r == keep_r) begin
            last_nxt = '0;
            v_nxt = ssl_pkg::BIG_COST;
          end else begin
            mask_nxt = mask_r + ssl_pkg::wmask_t'(1);
          end
        end else if (!mask_r[last_r[ssl_pkg::WSEL_W-1:0]]) begin
          last_nxt = last_r + ssl_pkg::WIDX_W'(1);
        end else if (mask_r == bit_last) begin
          best_we = 1'b1;
          best_wdata = ssl_pkg::SLEN_W'(wl_q);
          last_nxt = last_r + ssl_pkg::WIDX_W'(1);
        end else begin
          v_nxt = ssl_pkg::BIG_COST;
          p_nxt = '0;
        end
      end
      ssl_pkg::S_DP_P: begin
        if (p_end) begin
          best_we = 1'b1;
          best_wdata = v_r[ssl_pkg::SLEN_W-1:0];
          last_nxt = last_r + ssl_pkg::WIDX_W'(1);
        end else if (!sub[p_r[ssl_pkg::WSEL_W-1:0]]) begin
          p_nxt = p_r + ssl_pkg::WIDX_W'(1);
        end
      end
      ssl_pkg::S_DP_ADD: begin
        t_v = ssl_pkg::COST_W'(best_rdata) + ssl_pkg::COST_W'(ext_rdata);
        if (t_v < v_r) begin
          v_nxt = t_v;
        end
        p_nxt = p_r + ssl_pkg::WIDX_W'(1);
      end
      ssl_pkg::S_FIN_RD: begin
        if (last_end) begin
          res_len_nxt = v_r[ssl_pkg::SLEN_W-1:0];
          res_st_nxt = ssl_pkg::ST_OK;
        end else if (!keep_r[last_r[ssl_pkg::WSEL_W-1:0]]) begin
          last_nxt = last_r + ssl_pkg::WIDX_W'(1);
        end
      end
      ssl_pkg::S_FIN_CK: begin
        if (ssl_pkg::COST_W'(best_rdata) < v_r) begin
          v_nxt = ssl_pkg::COST_W'(best_rdata);
        end
        last_nxt = last_r + ssl_pkg::WIDX_W'(1);
      end
      ssl_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_len_nxt = res_len_r;
          out_st_nxt = res_st_r;
          wc_nxt = '0;
          cur_nxt = '0;
          err_nxt = 2'b00;
          keep_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssl_pkg::S_IDLE;
      wc_r        <= '0;
      cur_r       <= '0;
      err_r       <= 2'b00;
      keep_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wc_r        <= wc_nxt;
      cur_r       <= cur_nxt;
      err_r       <= err_nxt;
      keep_r      <= keep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ia_r      <= ia_nxt;
    jb_r      <= jb_nxt;
    ov_r      <= ov_nxt;
    la_r      <= la_nxt;
    lb_r      <= lb_nxt;
    off_r     <= off_nxt;
    len_r     <= len_nxt;
    pos_r     <= pos_nxt;
    mask_r    <= mask_nxt;
    last_r    <= last_nxt;
    p_r       <= p_nxt;
    v_r       <= v_nxt;
    res_len_r <= res_len_nxt;
    res_st_r  <= res_st_nxt;
    out_len_r <= out_len_nxt;
    out_st_r  <= out_st_nxt;
    if (wl_we) begin
      wl_r[wc_r[ssl_pkg::WSEL_W-1:0]] <= wl_wdata;
    end
  end

endmodule

[sv/ssl_chk.sv]
// Port-level assertion checker for the shortest superstring length block, with its bind
`timescale 1ns / 1ps
module ssl_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ssl_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [ssl_pkg::STAT_W-1:0]      out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ssl_pkg::ST_OK) || (out_tuser == ssl_pkg::ST_MANY)
                   || (out_tuser == ssl_pkg::ST_LONG))
    else $error("bad status");

  a_err_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ssl_pkg::ST_OK) |-> (out_tdata == '0))
    else $error("length on error");

  a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == ssl_pkg::FUNC_SOLVE) |=> !in_tready)
    else $error("request taken during solve");

  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid && in_tready)
    else $error("reset state wrong");

endmodule

bind shortest_superstring_length ssl_chk u_ssl_chk (.*);

[dv/ssl_checker.sv]
// Checker for the superstring length block: watches both channels, predicts and compares
`timescale 1ns / 1ps
module ssl_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [ssl_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [ssl_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [ssl_pkg::STAT_W-1:0]      out_tuser,
  output int                              fail_count,
  output int                              pending
);

  typedef struct packed {
    logic [ssl_pkg::SLEN_W-1:0] super_len;
    logic [ssl_pkg::STAT_W-1:0] status;
  } ssl_result_t;

  logic [ssl_pkg::CHAR_W-1:0] word_bytes [ssl_pkg::MAX_WORDS][ssl_pkg::MAX_CHARS];
  int                         word_len   [ssl_pkg::MAX_WORDS];
  int                         n_words;
  int                         open_len;
  logic [1:0]                 err_bits;
  ssl_result_t                result_q [$];

  function automatic bit word_holds(int h, int n);
    bit same;
    if (word_len[n] > word_len[h]) return 0;
    for (int s = 0; s + word_len[n] <= word_len[h]; s++) begin
      same = 1;
      for (int k = 0; k < word_len[n]; k++)
        if (word_bytes[h][s+k] != word_bytes[n][k]) same = 0;
      if (same) return 1;
    end
    return 0;
  endfunction

  function automatic int chars_added(int a, int b);
    int  la;
    int  lb;
    bit  same;
    la = word_len[a];
    lb = word_len[b];
    for (int k = (la < lb) ? la : lb; k > 0; k--) begin
      same = 1;
      for (int q = 0; q < k; q++)
        if (word_bytes[a][la-k+q] != word_bytes[b][q]) same = 0;
      if (same) return lb - k;
    end
    return lb;
  endfunction

  function automatic int superstring_len();
    bit keep [ssl_pkg::MAX_WORDS];
    int kept [ssl_pkg::MAX_WORDS];
    int m;
    int full;
    int v;
    int t;
    int ans;
    int gain [ssl_pkg::MAX_WORDS][ssl_pkg::MAX_WORDS];
    int best [];
    m = 0;
    for (int i = 0; i < n_words; i++) keep[i] = 1;
    for (int i = 0; i < n_words; i++)
      for (int j = 0; j < n_words; j++)
        if (i != j && keep[i] && keep[j] && word_holds(i, j)) keep[j] = 0;
    for (int i = 0; i < n_words; i++)
      if (keep[i]) begin
        kept[m] = i;
        m++;
      end
    if (m == 0) return 0;
    for (int i = 0; i < m; i++)
      for (int j = 0; j < m; j++) gain[i][j] = chars_added(kept[i], kept[j]);
    full = (1 << m) - 1;
    best = new[(full + 1) * m];
    for (int msk = 1; msk <= full; msk++)
      for (int l = 0; l < m; l++) begin
        if (!msk[l]) continue;
        if (msk == (1 << l)) begin
          v = word_len[kept[l]];
        end else begin
          v = 1 << 20;
          for (int p = 0; p < m; p++) begin
            if (!msk[p] || p == l) continue;
            t = best[(msk ^ (1 << l)) * m + p] + gain[p][l];
            if (t < v) v = t;
          end
        end
        best[msk * m + l] = v;
      end
    ans = 1 << 20;
    for (int l = 0; l < m; l++)
      if (best[full * m + l] < ans) ans = best[full * m + l];
    return ans;
  endfunction

  always @(posedge clk) begin
    ssl_result_t r;
    ssl_result_t got;
    if (!rst_n) begin
      n_words    = 0;
      open_len   = 0;
      err_bits   = '0;
      fail_count <= 0;
      result_q.delete();
      pending    <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (in_tuser == ssl_pkg::FUNC_LOAD) begin
          if (n_words >= ssl_pkg::MAX_WORDS) begin
            err_bits[0] = 1'b1;
          end else if (open_len >= ssl_pkg::MAX_CHARS) begin
            err_bits[1] = 1'b1;
          end else begin
            word_bytes[n_words][open_len] = in_tdata[ssl_pkg::CHAR_W-1:0];
            open_len = open_len + 1;
          end
          if (in_tlast) begin
            if (n_words < ssl_pkg::MAX_WORDS && open_len > 0) begin
              word_len[n_words] = open_len;
              n_words = n_words + 1;
            end
            open_len = 0;
          end
        end else begin
          r.super_len = '0;
          if (err_bits[0]) r.status = ssl_pkg::ST_MANY;
          else if (err_bits[1]) r.status = ssl_pkg::ST_LONG;
          else begin
            r.status    = ssl_pkg::ST_OK;
            r.super_len = ssl_pkg::SLEN_W'(superstring_len());
          end
          result_q.insert(result_q.size(), r);
          n_words  = 0;
          open_len = 0;
          err_bits = '0;
        end
      end
      if (out_tvalid && out_tready) begin
        got.super_len = out_tdata[ssl_pkg::SLEN_W-1:0];
        got.status    = out_tuser;
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result len=%0d status=%0d", $time, got.super_len,
                   got.status);
          fail_count <= fail_count + 1;
        end else begin
          r = result_q.pop_front();
          if (got !== r || out_tdata[ssl_pkg::OUT_TDATA_W-1:ssl_pkg::SLEN_W] !== '0) begin
            $display("%0t: expected len=%0d status=%0d, got len=%0d status=%0d (tdata %h)",
                     $time, r.super_len, r.status, got.super_len, got.status, out_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= result_q.size();
    end
  end

endmodule

[dv/tb_top.sv]
// Testbench top for the superstring length block: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
module tb_top;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [ssl_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            in_tuser;
  logic                            in_tlast;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [ssl_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [ssl_pkg::STAT_W-1:0]      out_tuser;
  int                              fail_count;
  int                              pending;
  int                              burst_left;
  int                              sent;
  int                              stall_cnt;

  shortest_superstring_length u_top (.*);

  ssl_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

  // receiver: ready always, on a fixed pattern, or at random, switching as stall_cnt[10:9] changes
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cnt  <= 0;
      out_tready <= 1'b0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      case (stall_cnt[10:9])
        2'd0:    out_tready <= 1'b1;
        2'd1:    out_tready <= (stall_cnt[4:2] != 3'b101);
        default: out_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic push_req(input logic f, input logic [7:0] ch, input logic we);
    logic acc;
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= ch;
    in_tlast  <= we;
    do begin
      @(negedge clk);
      acc = in_tready;
      @(posedge clk);
    end while (!acc);
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
  endtask

  task automatic load_word(input int len, input int base, input bit wide, input bit closed);
    logic [7:0] ch;
    for (int k = 0; k < len; k++) begin
      ch = wide ? 8'($urandom_range(0, 255)) : 8'(base + $urandom_range(0, 2));
      push_req(ssl_pkg::FUNC_LOAD, ch, closed && k == len - 1);
    end
  endtask

  task automatic solve_req();
    push_req(ssl_pkg::FUNC_SOLVE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic random_set();
    int  kind;
    int  nw;
    int  base;
    bit  wide;
    kind = $urandom_range(0, 19);
    base = $urandom_range(0, 253);
    wide = ($urandom_range(0, 3) == 0);
    case (kind)
      0: begin
        nw = $urandom_range(13, 15);
        for (int w = 0; w < nw; w++) load_word($urandom_range(1, 3), base, wide, 1);
      end
      1: begin
        load_word($urandom_range(1, 4), base, wide, 1);
        load_word($urandom_range(65, 70), base, wide, 1);
        if ($urandom_range(0, 1)) load_word($urandom_range(1, 4), base, wide, 1);
      end
      2: begin
        nw = $urandom_range(0, 3);
        for (int w = 0; w < nw; w++) load_word($urandom_range(1, 6), base, wide, 1);
        load_word($urandom_range(1, 5), base, wide, 0);
      end
      3: begin
        nw = $urandom_range(6, 8);
        for (int w = 0; w < nw; w++) load_word($urandom_range(1, 6), base, wide, 1);
      end
      4: begin
        nw = $urandom_range(1, 3);
        for (int w = 0; w < nw; w++) load_word($urandom_range(7, 64), base, wide, 1);
      end
      default: begin
        nw = $urandom_range(0, 5);
        for (int w = 0; w < nw; w++) load_word($urandom_range(1, 6), base, wide, 1);
      end
    endcase
    solve_req();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = ssl_pkg::FUNC_LOAD;
    in_tlast   = 1'b0;
    sent       = 0;
    burst_left = 8;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty set
    push_req(ssl_pkg::FUNC_SOLVE, 8'h00, 1'b0);
    // overlapping pair on the byte extremes
    push_req(ssl_pkg::FUNC_LOAD, 8'h00, 1'b0);
    push_req(ssl_pkg::FUNC_LOAD, 8'hFF, 1'b1);
    push_req(ssl_pkg::FUNC_LOAD, 8'hFF, 1'b0);
    push_req(ssl_pkg::FUNC_LOAD, 8'h80, 1'b1);
    push_req(ssl_pkg::FUNC_SOLVE, 8'hFF, 1'b1);
    // duplicate and contained words, then an open word dropped at solve
    push_req(ssl_pkg::FUNC_LOAD, 8'h41, 1'b1);
    push_req(ssl_pkg::FUNC_LOAD, 8'h41, 1'b1);
    push_req(ssl_pkg::FUNC_LOAD, 8'h42, 1'b0);
    push_req(ssl_pkg::FUNC_LOAD, 8'h41, 1'b1);
    push_req(ssl_pkg::FUNC_LOAD, 8'h43, 1'b0);
    push_req(ssl_pkg::FUNC_SOLVE, 8'h55, 1'b0);
    // twelve identical words fill the store without error
    for (int w = 0; w < ssl_pkg::MAX_WORDS; w++) push_req(ssl_pkg::FUNC_LOAD, 8'h7E, 1'b1);
    push_req(ssl_pkg::FUNC_SOLVE, 8'h00, 1'b0);

    while (sent < 1700) random_set();

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
sv/ssl_pkg.sv
sv/ssl_ram.sv
sv/shortest_superstring_length.sv
sv/ssl_chk.sv
dv/ssl_checker.sv
dv/tb_top.sv
